[rtl/gcsa_pkg.sv]
`default_nettype none

package gcsa_pkg;

    // Fixed field widths
    localparam int TILE_BITS     = 8;
    localparam int GW_BITS       = 11;
    localparam int GH_BITS       = 13;
    localparam int THR_BITS      = 4;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 13;

    // Geometry defaults and limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int MIN_DIM        = 3;
    // Column field in a queued op, wide enough for the largest supported row
    localparam int OP_COL_BITS    = 12;

    // Op queue between front and back
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    // Register reset values
    localparam logic [GW_BITS-1:0]   RST_GRID_WIDTH     = 11'd1024;
    localparam logic [GH_BITS-1:0]   RST_GRID_HEIGHT    = 13'd4096;
    localparam logic [TILE_BITS-1:0] RST_EMPTY_CODE     = 8'd0;
    localparam logic [TILE_BITS-1:0] RST_FILL_CODE      = 8'd1;
    localparam logic [THR_BITS-1:0]  RST_FILL_THRESHOLD = 4'd5;

    // Command code of an input word
    localparam logic CMD_DRAIN = 1'b1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GRID_WIDTH,
        CFG_GRID_HEIGHT,
        CFG_EMPTY_CODE,
        CFG_FILL_CODE,
        CFG_FILL_THRESHOLD
    } t_cfg_idx;

    typedef struct packed {
        logic                 cmd;
        logic [TILE_BITS-1:0] tile_in;
    } t_in_word;

    typedef struct packed {
        logic [TILE_BITS-1:0] tile_out;
        logic                 frame_last;
    } t_out_word;

    // One result to produce: classified by the front, carried out by the back
    typedef struct packed {
        logic                   smooth;
        logic                   last;
        logic [OP_COL_BITS-1:0] col;
        logic [TILE_BITS-1:0]   raw;
        logic [TILE_BITS-1:0]   right;
        logic [TILE_BITS-1:0]   dl;
        logic [TILE_BITS-1:0]   dc;
        logic [TILE_BITS-1:0]   dr;
    } t_op;

    typedef struct packed {
        logic push;
        t_op  op;
    } t_q_wr;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_q_rd;

    typedef struct packed {
        logic [TILE_BITS-1:0] empty_code;
        logic [TILE_BITS-1:0] fill_code;
        logic [THR_BITS-1:0]  fill_threshold;
    } t_rule_cfg;

endpackage

`default_nettype wire

[rtl/gcsa_front.sv]
`default_nettype none

module gcsa_front #(
    parameter int MAX_WIDTH  = gcsa_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gcsa_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    input  wire gcsa_pkg::t_in_word                 i_in_word,
    output logic                                    o_in_stall,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]     i_eff_w,
    input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]    i_eff_h,
    input  wire logic [gcsa_pkg::QCOUNT_BITS-1:0]   i_q_count,
    output gcsa_pkg::t_q_wr                         o_q_wr
);

    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int WB        = $clog2(MAX_WIDTH + 1);
    localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
    localparam int HB        = $clog2(MAX_HEIGHT + 1);
    localparam int PEND_BITS = $clog2(MAX_WIDTH + 2);
    localparam int SUMW      = gcsa_pkg::QCOUNT_BITS + 1;
    localparam int TB        = gcsa_pkg::TILE_BITS;

    // Raw row store: previous row as it arrived
    logic [TB-1:0] r_orig [MAX_WIDTH];

    logic [COL_BITS-1:0]  r_col, n_col;
    logic [COL_BITS-1:0]  r_res_col, n_res_col;
    logic [ROW_BITS-1:0]  r_res_row, n_res_row;
    logic [PEND_BITS-1:0] r_pend, n_pend;

    logic accept, drain, pend_gt_w, pend_zero, emit;
    logic col_wrap, res_col_wrap, res_row_wrap, interior, last;
    logic [COL_BITS-1:0] rd_addr;

    // Stage 1: accepted word and its classification, store read in flight
    logic                r_s1_valid;
    logic                r_s1_drain;
    logic                r_s1_emit;
    logic                r_s1_use_above;
    logic                r_s1_interior;
    logic                r_s1_last;
    logic [COL_BITS-1:0] r_s1_col;
    logic [TB-1:0]       r_s1_tile;
    logic [TB-1:0]       r_orig_rd;

    // Raw window: tile above the previous word, the two previous words
    logic [TB-1:0] r_above, r_in1, r_in2;

    // Hold off while the queue could not take the word in flight
    assign o_in_stall = !i_rst_n ||
        ((SUMW'(i_q_count) + SUMW'(r_s1_valid)) >= SUMW'(gcsa_pkg::QUEUE_DEPTH));

    // Classify the word and step the stream counters
    always_comb begin
        accept       = i_in_valid && !o_in_stall;
        drain        = (i_in_word.cmd == gcsa_pkg::CMD_DRAIN);
        pend_gt_w    = r_pend > PEND_BITS'(i_eff_w);
        pend_zero    = (r_pend == '0);
        emit         = drain ? !pend_zero : pend_gt_w;
        col_wrap     = (WB'(r_col) + WB'(1)) >= i_eff_w;
        res_col_wrap = (WB'(r_res_col) + WB'(1)) >= i_eff_w;
        res_row_wrap = (HB'(r_res_row) + HB'(1)) >= i_eff_h;
        interior     = (r_res_row != '0)
                    && ((HB+1)'(r_res_row) + (HB+1)'(2) <= (HB+1)'(i_eff_h))
                    && (r_res_col != '0)
                    && ((WB+1)'(r_res_col) + (WB+1)'(2) <= (WB+1)'(i_eff_w));
        last         = res_row_wrap && res_col_wrap;
        rd_addr      = drain ? r_res_col : r_col;

        n_col     = r_col;
        n_res_col = r_res_col;
        n_res_row = r_res_row;
        n_pend    = r_pend;
        if (accept) begin
            if (!drain) begin
                n_col = col_wrap ? '0 : r_col + COL_BITS'(1);
                if (!pend_gt_w) begin
                    n_pend = r_pend + PEND_BITS'(1);
                end
            end else if (!pend_zero) begin
                n_pend = r_pend - PEND_BITS'(1);
            end
            if (emit) begin
                if (res_col_wrap) begin
                    n_res_col = '0;
                    n_res_row = res_row_wrap ? '0 : r_res_row + ROW_BITS'(1);
                end else begin
                    n_res_col = r_res_col + COL_BITS'(1);
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_res_col  <= '0;
            r_res_row  <= '0;
            r_pend     <= '0;
            r_s1_valid <= 1'b0;
            r_above    <= '0;
            r_in1      <= '0;
            r_in2      <= '0;
        end else begin
            r_col      <= n_col;
            r_res_col  <= n_res_col;
            r_res_row  <= n_res_row;
            r_pend     <= n_pend;
            r_s1_valid <= accept;
            // window shifts once the tile's store read is back
            if (r_s1_valid && !r_s1_drain) begin
                r_in2   <= r_in1;
                r_in1   <= r_s1_tile;
                r_above <= r_orig_rd;
            end
        end
    end

    // Stage 1 payload and raw row store (read returns the old entry)
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_drain     <= drain;
            r_s1_emit      <= emit;
            r_s1_use_above <= pend_gt_w;
            r_s1_interior  <= interior;
            r_s1_last      <= last;
            r_s1_col       <= r_res_col;
            r_s1_tile      <= i_in_word.tile_in;
            r_orig_rd      <= r_orig[rd_addr];
            if (!drain) begin
                r_orig[r_col] <= i_in_word.tile_in;
            end
        end
    end

    // Stage 2: build the op for the back
    always_comb begin
        o_q_wr.push      = r_s1_valid && r_s1_emit;
        o_q_wr.op.smooth = !r_s1_drain && r_s1_interior;
        o_q_wr.op.last   = r_s1_last;
        o_q_wr.op.col    = gcsa_pkg::OP_COL_BITS'(r_s1_col);
        o_q_wr.op.raw    = (r_s1_drain && !r_s1_use_above) ? r_orig_rd : r_above;
        o_q_wr.op.right  = r_orig_rd;
        o_q_wr.op.dl     = r_in2;
        o_q_wr.op.dc     = r_in1;
        o_q_wr.op.dr     = r_s1_tile;
    end

endmodule

`default_nettype wire

[rtl/gcsa_queue.sv]
`default_nettype none

module gcsa_queue (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire gcsa_pkg::t_q_wr                  i_q_wr,
    input  wire logic                             i_pop,
    output gcsa_pkg::t_q_rd                       o_q_rd,
    output logic [gcsa_pkg::QCOUNT_BITS-1:0]      o_count
);

    localparam int DEPTH = gcsa_pkg::QUEUE_DEPTH;
    localparam int PB    = gcsa_pkg::QPTR_BITS;
    localparam int CB    = gcsa_pkg::QCOUNT_BITS;

    gcsa_pkg::t_op r_slot [DEPTH];
    logic [PB-1:0] r_wr_ptr, r_rd_ptr;
    logic [CB-1:0] r_count;

    // Pointers and fill level; the front never pushes into a full queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_q_wr.push) begin
                r_wr_ptr <= (r_wr_ptr == PB'(DEPTH - 1)) ? '0 : r_wr_ptr + PB'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PB'(DEPTH - 1)) ? '0 : r_rd_ptr + PB'(1);
            end
            unique case ({i_q_wr.push, i_pop})
                2'b10:   r_count <= r_count + CB'(1);
                2'b01:   r_count <= r_count - CB'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_q_wr.push) begin
            r_slot[r_wr_ptr] <= i_q_wr.op;
        end
    end

    assign o_q_rd.valid = (r_count != '0);
    assign o_q_rd.op    = r_slot[r_rd_ptr];
    assign o_count      = r_count;

endmodule

`default_nettype wire

[rtl/gcsa_back.sv]
`default_nettype none

module gcsa_back #(
    parameter int MAX_WIDTH = gcsa_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire gcsa_pkg::t_q_rd       i_q_rd,
    output logic                       o_pop,
    input  wire gcsa_pkg::t_rule_cfg   i_rule,
    output logic                       o_out_valid,
    output gcsa_pkg::t_out_word        o_out_word,
    input  wire logic                  i_out_stall
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int TB       = gcsa_pkg::TILE_BITS;

    // Updated row store: previous row after smoothing
    logic [TB-1:0] r_upd [MAX_WIDTH];

    // Read stage
    logic                r_a_valid;
    gcsa_pkg::t_op       r_a_op;
    logic [TB-1:0]       r_up_here, r_up_right;
    // Updated left-above and left neighbours
    logic [TB-1:0]       r_upsave, r_last;

    logic                  r_out_valid;
    gcsa_pkg::t_out_word   r_out_word;

    logic out_ready, a_ready, xfer;
    logic [COL_BITS-1:0] rd_col, rd_col_nx, a_col;
    logic [7:0] solid_vec;
    logic [gcsa_pkg::THR_BITS-1:0] n_solid;
    logic [TB-1:0] res;

    // Handshake between read stage and output word
    always_comb begin
        out_ready = !r_out_valid || !i_out_stall;
        xfer      = r_a_valid && out_ready;
        a_ready   = !r_a_valid || out_ready;
        o_pop     = i_q_rd.valid && a_ready;
        rd_col    = COL_BITS'(i_q_rd.op.col);
        rd_col_nx = (rd_col == COL_BITS'(MAX_WIDTH - 1)) ? rd_col : rd_col + COL_BITS'(1);
        a_col     = COL_BITS'(r_a_op.col);
    end

    // Moore count over the eight neighbours and the fill decision
    always_comb begin
        solid_vec = {r_upsave        != i_rule.empty_code,
                     r_up_here       != i_rule.empty_code,
                     r_up_right      != i_rule.empty_code,
                     r_last          != i_rule.empty_code,
                     r_a_op.right    != i_rule.empty_code,
                     r_a_op.dl       != i_rule.empty_code,
                     r_a_op.dc       != i_rule.empty_code,
                     r_a_op.dr       != i_rule.empty_code};
        n_solid   = gcsa_pkg::THR_BITS'($countones(solid_vec));
        res       = (r_a_op.smooth && (r_a_op.raw == i_rule.empty_code)
                     && (n_solid >= i_rule.fill_threshold)) ? i_rule.fill_code : r_a_op.raw;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_upsave    <= '0;
            r_last      <= '0;
        end else begin
            if (o_pop) begin
                r_a_valid <= 1'b1;
            end else if (xfer) begin
                r_a_valid <= 1'b0;
            end
            if (xfer) begin
                r_out_valid <= 1'b1;
                r_upsave    <= r_up_here;
                r_last      <= res;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Store reads on pop, write-back and output word on transfer.
    // A pop never reads the column written in the same cycle (w >= 3).
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_op     <= i_q_rd.op;
            r_up_here  <= r_upd[rd_col];
            r_up_right <= r_upd[rd_col_nx];
        end
        if (xfer) begin
            r_out_word.tile_out   <= res;
            r_out_word.frame_last <= r_a_op.last;
            r_upd[a_col]          <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

[rtl/grid_cave_smoothing_automaton_core.sv]
// A tile's own result is caused by the word grid_width+1 places later.
// Throughput: one word per cycle while the output is not stalled, set by one
//   write and two reads per cycle on the updated row store and one read and
//   one write per cycle on the raw row store.
// Reset: synchronous, active low; clears counters, window, op queue, output
//   and loads register defaults. The row stores are not cleared.
`default_nettype none

module grid_cave_smoothing_automaton_core #(
    parameter int MAX_WIDTH  = gcsa_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gcsa_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    input  wire gcsa_pkg::t_in_word                  i_in_word,
    output logic                                     o_in_stall,
    output logic                                     o_out_valid,
    output gcsa_pkg::t_out_word                      o_out_word,
    input  wire logic                                i_out_stall,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [gcsa_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [gcsa_pkg::CFG_DATA_BITS-1:0]  i_cfg_wr_data
);

    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);

    logic [gcsa_pkg::GW_BITS-1:0]   r_grid_width;
    logic [gcsa_pkg::GH_BITS-1:0]   r_grid_height;
    logic [gcsa_pkg::TILE_BITS-1:0] r_empty_code;
    logic [gcsa_pkg::TILE_BITS-1:0] r_fill_code;
    logic [gcsa_pkg::THR_BITS-1:0]  r_fill_threshold;

    logic [WB-1:0] eff_w;
    logic [HB-1:0] eff_h;
    gcsa_pkg::t_rule_cfg rule;

    gcsa_pkg::t_q_wr q_wr;
    gcsa_pkg::t_q_rd q_rd;
    logic            q_pop;
    logic [gcsa_pkg::QCOUNT_BITS-1:0] q_count;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width     <= gcsa_pkg::RST_GRID_WIDTH;
            r_grid_height    <= gcsa_pkg::RST_GRID_HEIGHT;
            r_empty_code     <= gcsa_pkg::RST_EMPTY_CODE;
            r_fill_code      <= gcsa_pkg::RST_FILL_CODE;
            r_fill_threshold <= gcsa_pkg::RST_FILL_THRESHOLD;
        end else if (i_cfg_wr_en) begin
            unique case (gcsa_pkg::t_cfg_idx'(i_cfg_idx))
                gcsa_pkg::CFG_GRID_WIDTH:
                    r_grid_width <= i_cfg_wr_data[gcsa_pkg::GW_BITS-1:0];
                gcsa_pkg::CFG_GRID_HEIGHT:
                    r_grid_height <= i_cfg_wr_data[gcsa_pkg::GH_BITS-1:0];
                gcsa_pkg::CFG_EMPTY_CODE:
                    r_empty_code <= i_cfg_wr_data[gcsa_pkg::TILE_BITS-1:0];
                gcsa_pkg::CFG_FILL_CODE:
                    r_fill_code <= i_cfg_wr_data[gcsa_pkg::TILE_BITS-1:0];
                gcsa_pkg::CFG_FILL_THRESHOLD:
                    r_fill_threshold <= i_cfg_wr_data[gcsa_pkg::THR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Geometry clamped into the supported range
    always_comb begin
        priority if (32'(r_grid_width) < 32'(gcsa_pkg::MIN_DIM)) begin
            eff_w = WB'(gcsa_pkg::MIN_DIM);
        end else if (32'(r_grid_width) > 32'(MAX_WIDTH)) begin
            eff_w = WB'(MAX_WIDTH);
        end else begin
            eff_w = WB'(r_grid_width);
        end
        priority if (32'(r_grid_height) < 32'(gcsa_pkg::MIN_DIM)) begin
            eff_h = HB'(gcsa_pkg::MIN_DIM);
        end else if (32'(r_grid_height) > 32'(MAX_HEIGHT)) begin
            eff_h = HB'(MAX_HEIGHT);
        end else begin
            eff_h = HB'(r_grid_height);
        end
        rule.empty_code     = r_empty_code;
        rule.fill_code      = r_fill_code;
        rule.fill_threshold = r_fill_threshold;
    end

    gcsa_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .i_eff_w    (eff_w),
        .i_eff_h    (eff_h),
        .i_q_count  (q_count),
        .o_q_wr     (q_wr)
    );

    gcsa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_wr  (q_wr),
        .i_pop   (q_pop),
        .o_q_rd  (q_rd),
        .o_count (q_count)
    );

    gcsa_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_rd      (q_rd),
        .o_pop       (q_pop),
        .i_rule      (rule),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

[rtl/gcsa_checker.sv]
`default_nettype none

module gcsa_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_in_stall,
    input wire logic                 o_out_valid,
    input wire gcsa_pkg::t_out_word  o_out_word,
    input wire logic                 i_out_stall
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("result word changed while stalled");

    // Reset empties the output
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // No word is taken in during reset
    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |-> o_in_stall)
        else $error("input not stalled in reset");

    // A taken frame-last word is never directly followed by another frame-last word
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_word.frame_last)
        |=> !(o_out_valid && o_out_word.frame_last))
        else $error("two consecutive frame-last words");

endmodule

bind grid_cave_smoothing_automaton_core gcsa_checker u_gcsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_word  (o_out_word),
    .i_out_stall (i_out_stall)
);

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import gcsa_pkg::*;

    localparam int          SETTLE_CYCLES  = 8;
    localparam int          END_CYCLES     = 20;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int unsigned RANDOM_WORDS   = 400;
    localparam int unsigned TALL_ROWS      = 30;
    localparam int unsigned WIDE_EXTRA     = 32;
    localparam logic        CMD_TILE       = ~CMD_DRAIN;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = 3'd7;
    localparam int          RAW_ROW        = 0;
    localparam int          UPD_ROW        = 1;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_e;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_in_valid    = 1'b0;
    t_in_word                 i_in_word     = '0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    t_out_word                o_out_word;
    logic                     i_out_stall   = 1'b0;
    logic                     i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_wr_data = '0;

    grid_cave_smoothing_automaton_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_word     (i_in_word),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .o_out_word    (o_out_word),
        .i_out_stall   (i_out_stall),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    // Smoothing predictor: register copy, row stores, window and counters
    logic [GW_BITS-1:0]   grid_w   = RST_GRID_WIDTH;
    logic [GH_BITS-1:0]   grid_h   = RST_GRID_HEIGHT;
    logic [TILE_BITS-1:0] air_code = RST_EMPTY_CODE;
    logic [TILE_BITS-1:0] fill_val = RST_FILL_CODE;
    logic [THR_BITS-1:0]  fill_min = RST_FILL_THRESHOLD;

    logic [TILE_BITS-1:0] row_mem [2][DEF_MAX_WIDTH];
    logic [TILE_BITS-1:0] win_above  = '0;
    logic [TILE_BITS-1:0] win_in1    = '0;
    logic [TILE_BITS-1:0] win_in2    = '0;
    logic [TILE_BITS-1:0] win_last   = '0;
    logic [TILE_BITS-1:0] win_upsave = '0;
    int unsigned          in_col     = 0;
    int unsigned          out_col    = 0;
    int unsigned          out_row    = 0;
    int unsigned          pend_cnt   = 0;

    // Smoothed tiles still owed by the block, oldest first
    t_out_word due_tiles [$];

    int unsigned err_cnt    = 0;
    int unsigned words_used = 0;
    int unsigned burst_left = 0;
    int unsigned quiet_cnt  = 0;

    function automatic int unsigned eff_w();
        int unsigned v;
        v = grid_w;
        if (v < MIN_DIM) v = MIN_DIM;
        if (v > DEF_MAX_WIDTH) v = DEF_MAX_WIDTH;
        return v;
    endfunction

    function automatic int unsigned eff_h();
        int unsigned v;
        v = grid_h;
        if (v < MIN_DIM) v = MIN_DIM;
        if (v > DEF_MAX_HEIGHT) v = DEF_MAX_HEIGHT;
        return v;
    endfunction

    function automatic logic [TILE_BITS-1:0] row_rd(int sel, int unsigned idx);
        return (idx < DEF_MAX_WIDTH) ? row_mem[sel][idx] : '0;
    endfunction

    function automatic int unsigned is_solid(logic [TILE_BITS-1:0] t);
        return (t != air_code) ? 1 : 0;
    endfunction

    // Result for the tile at the output position; smoothing only inside the border
    function automatic void emit_tile(logic [TILE_BITS-1:0] raw, bit smooth,
                                      logic [TILE_BITS-1:0] right, logic [TILE_BITS-1:0] dl,
                                      logic [TILE_BITS-1:0] dc, logic [TILE_BITS-1:0] dr);
        int unsigned          w, h, c, r, n;
        logic [TILE_BITS-1:0] res, up_here;
        t_out_word            ow;
        w = eff_w();
        h = eff_h();
        c = out_col;
        r = out_row;
        res = raw;
        up_here = row_rd(UPD_ROW, c);
        if (smooth && raw == air_code && r >= 1 && r + 2 <= h && c >= 1 && c + 2 <= w) begin
            n = is_solid(win_upsave) + is_solid(up_here) + is_solid(row_rd(UPD_ROW, c + 1))
              + is_solid(win_last) + is_solid(right)
              + is_solid(dl) + is_solid(dc) + is_solid(dr);
            if (n >= fill_min) res = fill_val;
        end
        win_upsave = up_here;
        if (c < DEF_MAX_WIDTH) row_mem[UPD_ROW][c] = res;
        win_last = res;
        ow.tile_out   = res;
        ow.frame_last = (r + 1 >= h && c + 1 >= w);
        due_tiles.push_back(ow);
        if (c + 1 >= w) begin
            out_col = 0;
            out_row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            out_col = c + 1;
        end
    endfunction

    // Advance the predictor by one accepted input word
    function automatic void smooth_step(t_in_word iw);
        int unsigned          w, c;
        logic [TILE_BITS-1:0] raw, v, above;
        w = eff_w();
        if (iw.cmd == CMD_DRAIN) begin
            if (pend_cnt == 0) return;
            raw = (pend_cnt > w) ? win_above : row_rd(RAW_ROW, out_col);
            emit_tile(raw, 1'b0, '0, '0, '0, '0);
            pend_cnt--;
        end else begin
            v = iw.tile_in;
            c = in_col;
            above = row_rd(RAW_ROW, c);
            if (c < DEF_MAX_WIDTH) row_mem[RAW_ROW][c] = v;
            pend_cnt++;
            if (pend_cnt > w + 1) begin
                emit_tile(win_above, 1'b1, above, win_in2, win_in1, v);
                pend_cnt--;
            end
            win_in2 = win_in1;
            win_in1 = v;
            win_above = above;
            in_col = (c + 1 >= w) ? 0 : c + 1;
        end
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_BITS-1:0] idx,
                                      logic [CFG_DATA_BITS-1:0] val);
        case (idx)
            CFG_GRID_WIDTH:     grid_w   = val[GW_BITS-1:0];
            CFG_GRID_HEIGHT:    grid_h   = val[GH_BITS-1:0];
            CFG_EMPTY_CODE:     air_code = val[TILE_BITS-1:0];
            CFG_FILL_CODE:      fill_val = val[TILE_BITS-1:0];
            CFG_FILL_THRESHOLD: fill_min = val[THR_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [TILE_BITS-1:0] pick_tile();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 4) return air_code;
        if (k < 6) return fill_val;
        return TILE_BITS'($urandom_range(0, 255));
    endfunction

    task automatic note_error(string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("%s", msg);
    endtask

    // Drop valid and wait for every owed tile to come out
    task automatic wait_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_tiles.size() != 0) @(posedge i_clk);
    endtask

    // Idle the block so that registers can be written safely
    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Send one word in bursts with random gaps; predict on acceptance
    task automatic send_word(input logic cmd, input logic [TILE_BITS-1:0] tile);
        t_in_word    iw;
        int unsigned gap;
        iw.cmd     = cmd;
        iw.tile_in = tile;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_word  <= iw;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
        if (cmd != CMD_DRAIN || pend_cnt != 0) words_used++;
        smooth_step(iw);
    endtask

    // Write all registers plus the unused index; junk above each narrower register's width
    task automatic load_regs(input logic [31:0] gw, input logic [31:0] gh,
                             input logic [7:0] ec, input logic [7:0] fc,
                             input logic [3:0] th);
        logic [CFG_IDX_BITS-1:0]  idxs [6];
        logic [CFG_DATA_BITS-1:0] vals [6];
        logic [31:0]              junk;
        int                       k;
        settle();
        junk = $urandom;
        idxs[0] = CFG_GRID_WIDTH;     vals[0] = {junk[1:0], gw[10:0]};
        idxs[1] = CFG_GRID_HEIGHT;    vals[1] = gh[12:0];
        idxs[2] = CFG_EMPTY_CODE;     vals[2] = {junk[6:2], ec};
        idxs[3] = CFG_FILL_CODE;      vals[3] = {junk[11:7], fc};
        idxs[4] = CFG_FILL_THRESHOLD; vals[4] = {junk[20:12], th};
        idxs[5] = CFG_IDX_SPARE;      vals[5] = junk[31:19];
        for (k = 0; k < 6; k++) begin
            i_cfg_wr_en   <= 1'b1;
            i_cfg_idx     <= idxs[k];
            i_cfg_wr_data <= vals[k];
            @(posedge i_clk);
            apply_reg(idxs[k], vals[k]);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    // One grid of tiles, with optional stray drains and at most one pause for results
    task automatic run_grid(input int noise_pct, input int pause_at);
        int unsigned total;
        int          i;
        total = eff_w() * eff_h();
        for (i = 0; i < total; i++) begin
            if (i == pause_at) wait_results();
            if ($urandom_range(0, 99) < noise_pct) begin
                send_word(CMD_DRAIN, TILE_BITS'($urandom_range(0, 255)));
            end
            send_word(CMD_TILE, pick_tile());
        end
    endtask

    // A run of tiles shorter than a grid, with optional stray drains
    task automatic run_tiles(input int noise_pct, input int unsigned count);
        int unsigned i;
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_word(CMD_DRAIN, TILE_BITS'($urandom_range(0, 255)));
            end
            send_word(CMD_TILE, pick_tile());
        end
    endtask

    // Drain everything still pending, sometimes one drain too many
    task automatic flush_grid();
        while (pend_cnt != 0) send_word(CMD_DRAIN, TILE_BITS'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0) begin
            send_word(CMD_DRAIN, TILE_BITS'($urandom_range(0, 255)));
        end
    endtask

    // Fill rule at both threshold ends, swapped codes, clamped geometry, idle drain
    task automatic test_directed();
        logic [7:0] ring [9];
        logic [7:0] slab [9];
        int         k;
        ring = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        slab = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        load_regs(0, 2, 8'h00, 8'hFF, 4'd8);
        send_word(CMD_DRAIN, 8'hA5);
        for (k = 0; k < 9; k++) send_word(CMD_TILE, ring[k]);
        flush_grid();
        load_regs(3, 3, 8'hFF, 8'h00, 4'd0);
        for (k = 0; k < 9; k++) send_word(CMD_TILE, slab[k]);
        flush_grid();
    endtask

    // Small random grids, back to back, with stray drains in some phases
    task automatic test_random_grids();
        int unsigned target, gw, gh, grids, g;
        logic [3:0]  th;
        int          noise, pause_at;
        bit          first;
        target = words_used + RANDOM_WORDS;
        first  = 1'b1;
        while (words_used < target) begin
            gw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(3, 8);
            gh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(3, 6);
            th = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(0, 8));
            load_regs(gw, gh, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), th);
            grids = $urandom_range(1, 3);
            noise = ($urandom_range(0, 3) == 0) ? 5 : 0;
            for (g = 0; g < grids; g++) begin
                pause_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15) : -1;
                if (first) pause_at = 5;
                first = 1'b0;
                run_grid(noise, pause_at);
            end
            flush_grid();
        end
    endtask

    // Narrowest row under the clamped height for a stretch of rows, then the
    // clamped widest row just past one row; its tail stays pending at the end
    task automatic test_extreme_geometry();
        load_regs(3, 8191, 8'h00, 8'hFF, 4'd4);
        run_tiles(2, TALL_ROWS * eff_w());
        flush_grid();
        load_regs(2047, 3, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  4'($urandom_range(0, 8)));
        run_tiles(0, eff_w() + WIDE_EXTRA);
    endtask

    // Receiver stall pattern: modes of random length
    stall_mode_e stall_mode = STALL_NONE;
    int unsigned stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = stall_mode_e'($urandom_range(0, 2));
            stall_left = $urandom_range(8, 64);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= 1'b0;
        endcase
    end

    // Result check against the oldest owed tile
    t_out_word got_exp;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_tiles.size() == 0) begin
                note_error($sformatf("unexpected word: tile %0h last %0b",
                                     o_out_word.tile_out, o_out_word.frame_last));
            end else begin
                got_exp = due_tiles.pop_front();
                if (o_out_word.tile_out !== got_exp.tile_out ||
                    o_out_word.frame_last !== got_exp.frame_last) begin
                    note_error($sformatf("mismatch: exp tile %0h last %0b, got tile %0h last %0b",
                                         got_exp.tile_out, got_exp.frame_last,
                                         o_out_word.tile_out, o_out_word.frame_last));
                end
            end
        end
    end

    // Watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cnt <= 0;
            end else if (quiet_cnt >= WATCHDOG_LIMIT) begin
                $display("tb: errors");
                $finish;
            end else begin
                quiet_cnt <= quiet_cnt + 1;
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_grids();
        test_extreme_geometry();
        wait_results();
        repeat (END_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/gcsa_pkg.sv
rtl/gcsa_front.sv
rtl/gcsa_queue.sv
rtl/gcsa_back.sv
rtl/grid_cave_smoothing_automaton_core.sv
rtl/gcsa_checker.sv
tb/sv/tb.sv
